FILE: src/c2ll_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, constants and helper functions for the Cartesian to
// latitude/longitude unit. No dependencies.
package c2ll_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int ANGLE_WIDTH   = 32;
    localparam int CORDIC_STAGES = 30;
    localparam int GUARD_BITS    = 8;
    localparam int OUT_WIDTH     = 32;

    localparam int DATA_W      = COORD_WIDTH + GUARD_BITS + 4;
    localparam int ACC_W       = 34;
    localparam int STAGE_IDX_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int ANGLE_SHIFT = 32 - ANGLE_WIDTH;
    localparam int ROUND_BIAS  = (ANGLE_SHIFT > 0) ? (1 << (ANGLE_SHIFT - 1)) : 0;

    localparam int IN_TDATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * OUT_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DATA_W-1:0]      data_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic signed [OUT_WIDTH-1:0]   angle_t;

    localparam acc_t HALF_PI_UNITS = acc_t'(64'sd1073741824);
    localparam acc_t PI_UNITS      = acc_t'(64'sd2147483648);

    typedef struct packed {
        logic valid;
        logic x_zero;
        logic x_neg;
        logic y_zero;
        logic y_neg;
        logic z_zero;
        logic z_neg;
        acc_t lon;
    } side_t;

    // atan(2^-i) in units of pi/2^31
    function automatic acc_t atan_units(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000518;
            20: v = 32'h0000028B;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return acc_t'({2'b00, v});
    endfunction

    function automatic acc_t clamp_quadrant(input acc_t a);
        acc_t r;
        r = a;
        if (a < 0)
            r = '0;
        else if (a > HALF_PI_UNITS)
            r = HALF_PI_UNITS;
        return r;
    endfunction

    // round half up to ANGLE_WIDTH, wrap, sign extend to the port width
    function automatic angle_t emit_angle(input acc_t a);
        acc_t                         r;
        logic signed [ANGLE_WIDTH-1:0] w;
        r = (a + acc_t'(ROUND_BIAS)) >>> ANGLE_SHIFT;
        w = r[ANGLE_WIDTH-1:0];
        return angle_t'(w);
    endfunction

endpackage

FILE: src/c2ll_cell.sv
`timescale 1ns / 1ps
// One CORDIC vectoring iteration with registered outputs.
// Depends on c2ll_pkg.
module c2ll_cell (
    input  logic                              clk,
    input  logic                              en,
    input  logic [c2ll_pkg::STAGE_IDX_W-1:0]  stage_idx,
    input  c2ll_pkg::data_t                   x_in,
    input  c2ll_pkg::data_t                   y_in,
    input  c2ll_pkg::acc_t                    ang_in,
    output c2ll_pkg::data_t                   x_out,
    output c2ll_pkg::acc_t                    ang_out,
    output c2ll_pkg::data_t                   y_out
);
    import c2ll_pkg::*;

    data_t x_reg, y_reg, x_next, y_next;
    acc_t  ang_reg, ang_next;
    data_t dx, dy;
    acc_t  step;

    always_comb
    begin
        dx   = y_in >>> stage_idx;
        dy   = x_in >>> stage_idx;
        step = atan_units(int'(stage_idx));
        if (!y_in[DATA_W-1])
        begin
            x_next   = x_in + dx;
            y_next   = y_in - dy;
            ang_next = ang_in + step;
        end
        else
        begin
            x_next   = x_in - dx;
            y_next   = y_in + dy;
            ang_next = ang_in - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = ang_reg;

endmodule

FILE: src/c2ll_prep.sv
`timescale 1ns / 1ps
// Input stage: unpacks a point, takes magnitudes with guard bits, records signs.
// Depends on c2ll_pkg.
module c2ll_prep (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [c2ll_pkg::IN_TDATA_W-1:0] in_data,
    output c2ll_pkg::side_t                side,
    output c2ll_pkg::data_t                hx,
    output c2ll_pkg::data_t                hy,
    output c2ll_pkg::data_t                zx
);
    import c2ll_pkg::*;

    coord_t x, y, z;
    data_t  xe, ye, ze;
    side_t  side_reg, side_next;
    data_t  hx_reg, hy_reg, zx_reg;

    always_comb
    begin
        x  = in_data[COORD_WIDTH-1:0];
        y  = in_data[2*COORD_WIDTH-1:COORD_WIDTH];
        z  = in_data[3*COORD_WIDTH-1:2*COORD_WIDTH];
        xe = data_t'(x);
        ye = data_t'(y);
        ze = data_t'(z);
        side_next        = '0;
        side_next.valid  = in_valid;
        side_next.x_zero = (x == '0);
        side_next.x_neg  = x[COORD_WIDTH-1];
        side_next.y_zero = (y == '0);
        side_next.y_neg  = y[COORD_WIDTH-1];
        side_next.z_zero = (z == '0);
        side_next.z_neg  = z[COORD_WIDTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (en)
            side_reg <= side_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg <= (xe[DATA_W-1] ? -xe : xe) <<< GUARD_BITS;
            hy_reg <= (ye[DATA_W-1] ? -ye : ye) <<< GUARD_BITS;
            zx_reg <= (ze[DATA_W-1] ? -ze : ze) <<< GUARD_BITS;
        end
    end

    assign side = side_reg;
    assign hx   = hx_reg;
    assign hy   = hy_reg;
    assign zx   = zx_reg;

endmodule

FILE: src/c2ll_final.sv
`timescale 1ns / 1ps
// Output stage: latitude special cases, angle rounding and the result register.
// Depends on c2ll_pkg.
module c2ll_final (
    input  logic                             clk,
    input  logic                             rst_n,
    input  c2ll_pkg::side_t                  side,
    input  c2ll_pkg::acc_t                   phi_raw,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [c2ll_pkg::OUT_TDATA_W-1:0] out_data
);
    import c2ll_pkg::*;

    logic   valid_reg;
    logic   take;
    acc_t   phi, lat;
    angle_t lat_reg, lon_reg;

    always_comb
    begin
        phi  = clamp_quadrant(phi_raw);
        take = !valid_reg || out_ready;
        if (side.z_zero)
            lat = '0;
        else if (side.x_zero && side.y_zero)
            lat = side.z_neg ? -HALF_PI_UNITS : HALF_PI_UNITS;
        else
            lat = side.z_neg ? -phi : phi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= side.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && side.valid)
        begin
            lat_reg <= emit_angle(lat);
            lon_reg <= emit_angle(side.lon);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {lon_reg, lat_reg};

endmodule

FILE: src/cartesian_to_lat_lon_unit.sv
`timescale 1ns / 1ps
// Cartesian point to latitude/longitude by CORDIC vectoring rows: x/y and z rows
// in parallel, then a chained latitude row. One transaction per cycle while the
// pipeline advances: whenever the result register is free, being taken, or the
// last stage is empty. Reset clears all valid flags; the pipeline then runs empty.
// Depends on c2ll_pkg, c2ll_prep, c2ll_cell, c2ll_final.
module cartesian_to_lat_lon_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // x_coord [31:0], y_coord [63:32], z_coord [95:64]
    input  logic [c2ll_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // latitude [31:0], longitude [63:32]
    output logic [c2ll_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import c2ll_pkg::*;

    localparam int S = CORDIC_STAGES;

    logic  advance;
    side_t side1 [0:S];
    side_t side2 [0:S];
    data_t hx [0:S];
    data_t hy [0:S];
    acc_t  ha [0:S];
    data_t zx [0:S];
    data_t zy [0:S];
    acc_t  za [0:S];
    data_t px [0:S];
    data_t py [0:S];
    acc_t  pa [0:S];
    acc_t  t_quad;

    assign advance       = !m_axis_tvalid || m_axis_tready || !side2[S].valid;
    assign s_axis_tready = advance;

    c2ll_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .side     (side1[0]),
        .hx       (hx[0]),
        .hy       (hy[0]),
        .zx       (zx[0])
    );

    assign ha[0] = '0;
    assign zy[0] = '0;
    assign za[0] = '0;

    // longitude from the first row's quadrant angle
    always_comb
    begin
        t_quad   = clamp_quadrant(ha[S]);
        side2[0] = side1[S];
        if (side1[S].x_zero && side1[S].y_zero)
            side2[0].lon = '0;
        else if (side1[S].x_zero)
            side2[0].lon = side1[S].y_neg ? -HALF_PI_UNITS : HALF_PI_UNITS;
        else if (side1[S].y_zero)
            side2[0].lon = side1[S].x_neg ? -PI_UNITS : '0;
        else if (!side1[S].x_neg)
            side2[0].lon = side1[S].y_neg ? -t_quad : t_quad;
        else
            side2[0].lon = side1[S].y_neg ? (t_quad - PI_UNITS) : (PI_UNITS - t_quad);
    end

    assign px[0] = hx[S];
    assign py[0] = zx[S];
    assign pa[0] = '0;

    for (genvar k = 0; k < S; k++)
    begin : g_row
        localparam logic [STAGE_IDX_W-1:0] IDX = STAGE_IDX_W'(k);

        c2ll_cell u_h (
            .clk       (clk),
            .en        (advance),
            .stage_idx (IDX),
            .x_in      (hx[k]),
            .y_in      (hy[k]),
            .ang_in    (ha[k]),
            .x_out     (hx[k+1]),
            .ang_out   (ha[k+1]),
            .y_out     (hy[k+1])
        );

        c2ll_cell u_z (
            .clk       (clk),
            .en        (advance),
            .stage_idx (IDX),
            .x_in      (zx[k]),
            .y_in      (zy[k]),
            .ang_in    (za[k]),
            .x_out     (zx[k+1]),
            .ang_out   (za[k+1]),
            .y_out     (zy[k+1])
        );

        c2ll_cell u_p (
            .clk       (clk),
            .en        (advance),
            .stage_idx (IDX),
            .x_in      (px[k]),
            .y_in      (py[k]),
            .ang_in    (pa[k]),
            .x_out     (px[k+1]),
            .ang_out   (pa[k+1]),
            .y_out     (py[k+1])
        );

        side_t s1_reg, s2_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s1_reg <= '0;
                s2_reg <= '0;
            end
            else if (advance)
            begin
                s1_reg <= side1[k];
                s2_reg <= side2[k];
            end
        end

        assign side1[k+1] = s1_reg;
        assign side2[k+1] = s2_reg;
    end

    c2ll_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .side      (side2[S]),
        .phi_raw   (pa[S]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cartesian_to_lat_lon_unit: streams 3-D points in
// and checks latitude/longitude against an in-bench CORDIC predictor.
// Depends on c2ll_pkg and the unit RTL.
module tb;

    typedef struct {
        c2ll_pkg::coord_t x;
        c2ll_pkg::coord_t y;
        c2ll_pkg::coord_t z;
    } point_t;

    typedef struct {
        c2ll_pkg::angle_t lat;
        c2ll_pkg::angle_t lon;
    } fix_t;

    localparam int     RUN_LIMIT = 200000;
    localparam int     HOLD_LEN  = 300;
    localparam longint HALF_PI   = 64'sd1073741824;
    localparam longint FULL_PI   = 64'sd2147483648;

    localparam c2ll_pkg::coord_t C_MAX = {1'b0, {(c2ll_pkg::COORD_WIDTH-1){1'b1}}};
    localparam c2ll_pkg::coord_t C_MIN = ~C_MAX;

    // atan(2^-i), units of pi/2^31
    localparam longint ATAN_LUT [32] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000518, 'h0000028B, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
        'h00000001, 'h00000000
    };

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [c2ll_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [c2ll_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;

    point_t point_q[$];
    fix_t   fix_q[$];
    logic   in_taken       = 1'b0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_req       = 0;
    int     hold_done      = 0;
    int     hold_left      = 0;
    int     mismatch_cnt   = 0;
    int     cycle_cnt      = 0;

    cartesian_to_lat_lon_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic void cordic_vec(inout longint vx, inout longint vy,
                                       output longint ang);
        longint dx;
        longint dy;
        ang = 0;
        for (int i = 0; i < c2ll_pkg::CORDIC_STAGES; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                ang = ang + ((i < 32) ? ATAN_LUT[i] : 0);
            end
            else
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                ang = ang - ((i < 32) ? ATAN_LUT[i] : 0);
            end
        end
    endfunction

    function automatic longint quad_clamp(input longint a);
        if (a < 0)
            return 0;
        if (a > HALF_PI)
            return HALF_PI;
        return a;
    endfunction

    function automatic c2ll_pkg::angle_t to_bam(input longint a);
        int     sh;
        longint r;
        sh = 32 - c2ll_pkg::ANGLE_WIDTH;
        r  = a;
        if (sh > 0)
            r = (r + (longint'(1) << (sh - 1))) >>> sh;
        r = (r <<< (64 - c2ll_pkg::ANGLE_WIDTH)) >>> (64 - c2ll_pkg::ANGLE_WIDTH);
        return r[31:0];
    endfunction

    function automatic fix_t point_to_fix(input point_t p);
        longint x, y, z, hx, hy, zx, zy, px, py, t, phi, lon, lat, unused;
        fix_t   f;
        x  = p.x;
        y  = p.y;
        z  = p.z;
        hx = (x < 0 ? -x : x) <<< c2ll_pkg::GUARD_BITS;
        hy = (y < 0 ? -y : y) <<< c2ll_pkg::GUARD_BITS;
        zx = (z < 0 ? -z : z) <<< c2ll_pkg::GUARD_BITS;
        zy = 0;
        cordic_vec(hx, hy, t);
        t = quad_clamp(t);
        cordic_vec(zx, zy, unused);

        if (x == 0 && y == 0)
            lon = 0;
        else if (x == 0)
            lon = (y > 0) ? HALF_PI : -HALF_PI;
        else if (y == 0)
            lon = (x > 0) ? 0 : -FULL_PI;
        else if (x > 0)
            lon = (y > 0) ? t : -t;
        else
            lon = (y > 0) ? (FULL_PI - t) : (t - FULL_PI);

        if (z == 0)
            lat = 0;
        else if (x == 0 && y == 0)
            lat = (z > 0) ? HALF_PI : -HALF_PI;
        else
        begin
            px = hx;
            py = zx;
            cordic_vec(px, py, phi);
            phi = quad_clamp(phi);
            lat = (z > 0) ? phi : -phi;
        end

        f.lat = to_bam(lat);
        f.lon = to_bam(lon);
        return f;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic c2ll_pkg::coord_t any_coord();
        case ($urandom_range(7))
            0: return '0;
            1: return $urandom_range(1) ? C_MIN : C_MAX;
            2: return $urandom_range(1) ? c2ll_pkg::coord_t'($urandom_range(16))
                                        : -c2ll_pkg::coord_t'($urandom_range(16));
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_point(input c2ll_pkg::coord_t x, input c2ll_pkg::coord_t y,
                               input c2ll_pkg::coord_t z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        point_q.push_back(p);
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (point_q.size() != 0 || (s_axis_tvalid && !in_taken) || fix_q.size() != 0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n,
                             input bit with_hold);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (with_hold)
            hold_req++;
        repeat (n)
            queue_point(any_coord(), any_coord(), any_coord());
        wait_drain();
    endtask

    task automatic log_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // ---------------- driver, receiver, monitor ----------------

    always @(negedge clk)
    begin
        point_t p;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                p = point_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {p.z, p.y, p.x};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_done != hold_req)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= hold_done + 1;
        end
    end

    always @(negedge clk)
        m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        fix_t   want;
        point_t p;
        c2ll_pkg::angle_t got_lat, got_lon;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_lat = m_axis_tdata[31:0];
            got_lon = m_axis_tdata[63:32];
            if (fix_q.size() == 0)
                log_mismatch($sformatf("unexpected transaction lat %0d lon %0d",
                                       got_lat, got_lon));
            else
            begin
                want = fix_q.pop_front();
                if (got_lat !== want.lat)
                    log_mismatch($sformatf("latitude got %0d want %0d", got_lat, want.lat));
                if (got_lon !== want.lon)
                    log_mismatch($sformatf("longitude got %0d want %0d", got_lon, want.lon));
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            p.x = s_axis_tdata[31:0];
            p.y = s_axis_tdata[63:32];
            p.z = s_axis_tdata[95:64];
            fix_q.push_back(point_to_fix(p));
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_cnt, fix_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_point(0, 0, 0);
        queue_point(0, 0, C_MAX);
        queue_point(0, 0, C_MIN);
        queue_point(C_MAX, 0, 0);
        queue_point(C_MIN, 0, 0);
        queue_point(0, C_MAX, 0);
        queue_point(0, C_MIN, 5);
        queue_point(C_MAX, C_MAX, C_MAX);
        queue_point(C_MIN, C_MIN, C_MIN);
        queue_point(C_MIN, C_MAX, 1);
        queue_point(-1, 1, -1);
        queue_point(1, -1, 1);
        queue_point(-5, 0, 3);
        queue_point(0, -7, 0);
        queue_point(-1000, 999, -20);
        queue_point(-1000, -999, 20);
        queue_point(C_MIN, 1, C_MAX);
        queue_point(C_MIN, -1, C_MIN);
        queue_point(1, 1, C_MIN);
        queue_point(C_MAX, -1, -1);
        run_phase(0, 0, 0, 1'b0);

        run_phase(0, 0, 150, 1'b0);
        run_phase(47, 0, 150, 1'b0);
        run_phase(0, 47, 150, 1'b0);
        run_phase(15, 15, 150, 1'b0);
        run_phase(0, 0, 120, 1'b1);

        repeat (2 * c2ll_pkg::CORDIC_STAGES + 10) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
src/c2ll_pkg.sv
src/c2ll_cell.sv
src/c2ll_prep.sv
src/c2ll_final.sv
src/cartesian_to_lat_lon_unit.sv
tb/sv/tb.sv
